// File: hdl/tbb_pkg.sv
// shared types and constants of the transform and bounding box core
package tbb_pkg;

    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int REG_COUNT         = 6;
    localparam int CFG_INDEX_W       = 3;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    // register reset values form the identity matrix
    localparam logic [63:0] ROW0_COLS01_RESET = 64'h0001_0000_0000_0000;
    localparam logic [63:0] ROW0_COLS23_RESET = 64'h0;
    localparam logic [63:0] ROW1_COLS01_RESET = 64'h0000_0000_0001_0000;
    localparam logic [63:0] ROW1_COLS23_RESET = 64'h0;
    localparam logic [63:0] ROW2_COLS01_RESET = 64'h0;
    localparam logic [63:0] ROW2_COLS23_RESET = 64'h0001_0000_0000_0000;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [30:0]        weight;
        logic               div_en;
        logic               zero_w;
        logic               xf_en;
        logic               last;
    } tbb_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_ACC,
        ST_UPD
    } tbb_state_t;

endpackage

// File: hdl/tbb_front.sv
// front end: accepts poles and classifies the work each one needs
module tbb_front
    import tbb_pkg::*;
(
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] pole_x,
    input  logic signed [31:0] pole_y,
    input  logic signed [31:0] pole_z,
    input  logic [30:0]        weight,
    input  logic               use_weight,
    input  logic               apply_transform,
    input  logic               last_pole,
    input  logic               q_full,
    output logic               q_push,
    output tbb_item_t          q_item
);

    assign in_stall = q_full;
    assign q_push   = in_valid & ~q_full;

    always_comb
    begin
        q_item.x      = pole_x;
        q_item.y      = pole_y;
        q_item.z      = pole_z;
        q_item.weight = weight;
        q_item.div_en = use_weight;
        q_item.zero_w = use_weight & (weight == '0);
        q_item.xf_en  = apply_transform;
        q_item.last   = last_pole;
    end

endmodule

// File: hdl/tbb_queue.sv
// short queue of classified poles between front and back
module tbb_queue
    import tbb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  tbb_item_t push_item,
    input  logic      pop,
    output tbb_item_t pop_item,
    output logic      full,
    output logic      empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    tbb_item_t        mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = mem_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(QUEUE_DEPTH - 1))
            return '0;
        return p + 1'b1;
    endfunction

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push && !full)
            wr_ptr_next = ptr_inc(wr_ptr_reg);
        if (pop && !empty)
            rd_ptr_next = ptr_inc(rd_ptr_reg);
        if ((push && !full) && !(pop && !empty))
            count_next = count_reg + 1'b1;
        else if (!(push && !full) && (pop && !empty))
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// File: hdl/tbb_back.sv
// back end: divider, transform sequencer, running extrema and result register
module tbb_back
    import tbb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_empty,
    input  tbb_item_t              q_item,
    output logic                   q_pop,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]            cfg_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic signed [31:0]     min_x,
    output logic signed [31:0]     min_y,
    output logic signed [31:0]     min_z,
    output logic signed [31:0]     max_x,
    output logic signed [31:0]     max_y,
    output logic signed [31:0]     max_z,
    output logic                   zero_weight_seen
);

    localparam int DW    = 32 + FRAC_BITS;
    localparam int CNT_W = $clog2(DW + 1);
    localparam logic [DW-1:0] Q_NEG_LIM = DW'(64'h8000_0000);
    localparam logic [DW-1:0] Q_POS_LIM = DW'(64'h7fff_ffff);
    // 1.0 in the configured fixed-point format
    localparam logic [31:0]   FX_ONE    = 32'(64'd1 << FRAC_BITS);

    logic [63:0] mat_reg [REG_COUNT];

    tbb_state_t         state_reg, state_next;
    tbb_item_t          item_reg, item_next;
    logic signed [31:0] pt_reg [3];
    logic signed [31:0] pt_next [3];
    logic signed [31:0] res_reg [3];
    logic signed [31:0] res_next [3];
    logic [1:0]         axis_reg, axis_next;
    logic [1:0]         col_reg, col_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DW-1:0]      div_reg, div_next;
    logic [30:0]        rem_reg, rem_next;
    logic               neg_reg, neg_next;
    logic signed [63:0] prod_reg, prod_next;
    logic signed [65:0] acc_reg, acc_next;
    logic signed [31:0] rmin_reg [3];
    logic signed [31:0] rmin_next [3];
    logic signed [31:0] rmax_reg [3];
    logic signed [31:0] rmax_next [3];
    logic               zflag_reg, zflag_next;
    logic signed [31:0] omin_reg [3];
    logic signed [31:0] omin_next [3];
    logic signed [31:0] omax_reg [3];
    logic signed [31:0] omax_next [3];
    logic               oz_reg, oz_next;
    logic               out_valid_reg, out_valid_next;

    // combinational helpers
    logic [31:0]        div_trial;
    logic [30:0]        div_rem;
    logic               div_bit;
    logic [DW-1:0]      div_q;
    logic [31:0]        mag;
    logic signed [31:0] coef;
    logic signed [31:0] tr;
    logic signed [65:0] acc_sum;
    logic signed [65:0] row_val;
    logic signed [31:0] val [3];
    logic               out_free;

    assign out_valid        = out_valid_reg;
    assign min_x            = omin_reg[0];
    assign min_y            = omin_reg[1];
    assign min_z            = omin_reg[2];
    assign max_x            = omax_reg[0];
    assign max_y            = omax_reg[1];
    assign max_z            = omax_reg[2];
    assign zero_weight_seen = oz_reg;
    assign out_free         = ~out_valid_reg | ~out_stall;

    // one restoring divide step
    always_comb
    begin
        div_trial = {1'b0, rem_reg} << 1 | 32'(div_reg[DW-1]);
        div_bit   = (div_trial >= {1'b0, item_reg.weight});
        div_rem   = div_bit ? 31'(div_trial - {1'b0, item_reg.weight}) : div_trial[30:0];
        div_q     = {div_reg[DW-2:0], div_bit};
        mag       = pt_reg[axis_reg][31] ? 32'(-pt_reg[axis_reg]) : pt_reg[axis_reg];
    end

    // matrix coefficient for the current row and column, translation and running row sum
    always_comb
    begin
        case (col_reg)
            2'd0:    coef = mat_reg[{axis_reg, 1'b0}][63:32];
            2'd1:    coef = mat_reg[{axis_reg, 1'b0}][31:0];
            default: coef = mat_reg[{axis_reg, 1'b1}][63:32];
        endcase
        tr      = mat_reg[{axis_reg, 1'b1}][31:0];
        acc_sum = ((col_reg == 2'd0) ? 66'sd0 : acc_reg) + 66'(prod_reg);
        row_val = (acc_sum >>> FRAC_BITS) + 66'(tr);
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            val[i] = item_reg.xf_en ? res_reg[i] : pt_reg[i];
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        pt_next        = pt_reg;
        res_next       = res_reg;
        axis_next      = axis_reg;
        col_next       = col_reg;
        cnt_next       = cnt_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        neg_next       = neg_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        rmin_next      = rmin_reg;
        rmax_next      = rmax_reg;
        zflag_next     = zflag_reg;
        omin_next      = omin_reg;
        omax_next      = omax_reg;
        oz_next        = oz_reg;
        out_valid_next = out_valid_reg & out_stall;
        q_pop          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    item_next  = q_item;
                    pt_next[0] = q_item.x;
                    pt_next[1] = q_item.y;
                    pt_next[2] = q_item.z;
                    axis_next  = 2'd0;
                    col_next   = 2'd0;
                    cnt_next   = '0;
                    if (q_item.div_en)
                        state_next = ST_DIV;
                    else if (q_item.xf_en)
                        state_next = ST_MUL;
                    else
                        state_next = ST_UPD;
                end
            end

            ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    if (item_reg.zero_w)
                    begin
                        // zero weight saturates by sign of the coordinate
                        if (pt_reg[axis_reg] > 0)
                            pt_next[axis_reg] = S32_MAX;
                        else if (pt_reg[axis_reg] < 0)
                            pt_next[axis_reg] = S32_MIN;
                        if (axis_reg == 2'd2)
                        begin
                            axis_next  = 2'd0;
                            state_next = item_reg.xf_en ? ST_MUL : ST_UPD;
                        end
                        else
                            axis_next = axis_reg + 1'b1;
                    end
                    else
                    begin
                        neg_next = pt_reg[axis_reg][31];
                        div_next = {mag, FRAC_BITS'(0)};
                        rem_next = '0;
                        cnt_next = CNT_W'(1);
                    end
                end
                else
                begin
                    div_next = div_q;
                    rem_next = div_rem;
                    if (cnt_reg == CNT_W'(DW))
                    begin
                        cnt_next = '0;
                        if (neg_reg)
                            pt_next[axis_reg] = (div_q > Q_NEG_LIM) ? S32_MIN
                                                : 32'(-div_q[31:0]);
                        else
                            pt_next[axis_reg] = (div_q > Q_POS_LIM) ? S32_MAX
                                                : div_q[31:0];
                        if (axis_reg == 2'd2)
                        begin
                            axis_next  = 2'd0;
                            state_next = item_reg.xf_en ? ST_MUL : ST_UPD;
                        end
                        else
                            axis_next = axis_reg + 1'b1;
                    end
                    else
                        cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_MUL:
            begin
                prod_next  = coef * pt_reg[col_reg];
                state_next = ST_ACC;
            end

            ST_ACC:
            begin
                acc_next = acc_sum;
                if (col_reg == 2'd2)
                begin
                    if (row_val > 66'(S32_MAX))
                        res_next[axis_reg] = S32_MAX;
                    else if (row_val < 66'(S32_MIN))
                        res_next[axis_reg] = S32_MIN;
                    else
                        res_next[axis_reg] = row_val[31:0];
                    col_next = 2'd0;
                    if (axis_reg == 2'd2)
                    begin
                        axis_next  = 2'd0;
                        state_next = ST_UPD;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 1'b1;
                        state_next = ST_MUL;
                    end
                end
                else
                begin
                    col_next   = col_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end

            ST_UPD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rmin_next[i] = (val[i] < rmin_reg[i]) ? val[i] : rmin_reg[i];
                    rmax_next[i] = (val[i] > rmax_reg[i]) ? val[i] : rmax_reg[i];
                end
                zflag_next = zflag_reg | item_reg.zero_w;
                if (!item_reg.last)
                    state_next = ST_IDLE;
                else if (out_free)
                begin
                    omin_next      = rmin_next;
                    omax_next      = rmax_next;
                    oz_next        = zflag_next;
                    out_valid_next = 1'b1;
                    for (int i = 0; i < 3; i++)
                    begin
                        rmin_next[i] = S32_MAX;
                        rmax_next[i] = S32_MIN;
                    end
                    zflag_next = 1'b0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    rmin_next  = rmin_reg;
                    rmax_next  = rmax_reg;
                    zflag_next = zflag_reg;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            zflag_reg     <= 1'b0;
            axis_reg      <= 2'd0;
            col_reg       <= 2'd0;
            cnt_reg       <= '0;
            for (int i = 0; i < 3; i++)
            begin
                rmin_reg[i] <= S32_MAX;
                rmax_reg[i] <= S32_MIN;
            end
            // identity matrix in the configured format
            mat_reg[0] <= {FX_ONE, 32'd0};
            mat_reg[1] <= 64'd0;
            mat_reg[2] <= {32'd0, FX_ONE};
            mat_reg[3] <= 64'd0;
            mat_reg[4] <= 64'd0;
            mat_reg[5] <= {FX_ONE, 32'd0};
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            zflag_reg     <= zflag_next;
            axis_reg      <= axis_next;
            col_reg       <= col_next;
            cnt_reg       <= cnt_next;
            rmin_reg      <= rmin_next;
            rmax_reg      <= rmax_next;
            if (cfg_valid && (cfg_index < CFG_INDEX_W'(REG_COUNT)))
                mat_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        pt_reg   <= pt_next;
        res_reg  <= res_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        neg_reg  <= neg_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        omin_reg <= omin_next;
        omax_reg <= omax_next;
        oz_reg   <= oz_next;
    end

    a_div_needs_weight: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> item_reg.div_en)
        else $error("divider running on an unweighted pole");

    a_xf_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_MUL) || (state_reg == ST_ACC)) |-> item_reg.xf_en)
        else $error("transform running on a pole without transform");

    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_UPD) && item_reg.last && out_free) |=> out_valid_reg)
        else $error("last pole did not produce a result");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == ST_IDLE))
        else $error("queue popped while back end busy");

endmodule

// File: hdl/transform_and_bounding_box_core.sv
// top level of the affine transform and bounding box core
// Poles enter on the input channel and are classified by the front end into a two
// entry queue, so the input keeps accepting while the back end works, until the queue
// is full. The back end takes one pole at a time: an unweighted, untransformed pole
// is loaded and then updates the extrema; weighting adds the bit serial restoring
// divider (one quotient bit a cycle per axis, Q16.16 by default), a zero weight skips
// it, saturating each axis by its sign; the transform adds the single 32x32
// multiplier and accumulator (nine products, multiply then accumulate). On the
// pole marked last the six extrema and the zero weight flag land in the result
// register, which holds a transaction until taken while the next list goes on.
// Matrix registers are written through the config channel, always ready; write
// them only while the block is idle. Indexes beyond 5 are ignored.
module transform_and_bounding_box_core
    import tbb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // pole input channel
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic signed [31:0]     pole_x,
    input  logic signed [31:0]     pole_y,
    input  logic signed [31:0]     pole_z,
    input  logic [30:0]            weight,
    input  logic                   use_weight,
    input  logic                   apply_transform,
    input  logic                   last_pole,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]            cfg_data,
    // result channel
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic signed [31:0]     min_x,
    output logic signed [31:0]     min_y,
    output logic signed [31:0]     min_z,
    output logic signed [31:0]     max_x,
    output logic signed [31:0]     max_y,
    output logic signed [31:0]     max_z,
    output logic                   zero_weight_seen
);

    tbb_item_t push_item;
    tbb_item_t pop_item;
    logic      q_push;
    logic      q_pop;
    logic      q_full;
    logic      q_empty;

    // register writes are always accepted
    assign cfg_ready = 1'b1;

    tbb_front u_front
    (
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .pole_x          (pole_x),
        .pole_y          (pole_y),
        .pole_z          (pole_z),
        .weight          (weight),
        .use_weight      (use_weight),
        .apply_transform (apply_transform),
        .last_pole       (last_pole),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_item          (push_item)
    );

    tbb_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    tbb_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_empty          (q_empty),
        .q_item           (pop_item),
        .q_pop            (q_pop),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .min_x            (min_x),
        .min_y            (min_y),
        .min_z            (min_z),
        .max_x            (max_x),
        .max_y            (max_y),
        .max_z            (max_z),
        .zero_weight_seen (zero_weight_seen)
    );

endmodule
